[src/sta_pkg.sv]
// Shared types and constants for the striped tag allocator.
package sta_pkg;

   // Field widths.
   localparam int TAG_W    = 31;
   localparam int WS_W     = 16;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W   = TAG_W + WS_W;

   // Reset value of the local index bound.
   localparam logic [TAG_W-1:0] INDEX_LIMIT_RESET = 31'd2100000000;

   // Request kinds.
   localparam logic KIND_GET    = 1'b0;
   localparam logic KIND_RETURN = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_WORLD_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANK        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_LIMIT = 2'd2;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 2'd0,
      STATUS_EXHAUSTED   = 2'd1,
      STATUS_WRONG_OWNER = 2'd2,
      STATUS_STACK_FULL  = 2'd3
   } status_type;

endpackage

[src/sta_divider.sv]
// Bit-serial restoring divider: tag divided by world size, one quotient bit per cycle.
module sta_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sta_pkg::TAG_W-1:0]  dividend,
   input  logic [sta_pkg::WS_W-1:0]   divisor,
   output logic                       done,
   output logic [sta_pkg::TAG_W-1:0]  quotient,
   output logic [sta_pkg::WS_W-1:0]   remainder
);
   import sta_pkg::*;

   localparam int CNT_W = $clog2(TAG_W);

   logic [TAG_W-1:0] quo_ff, quo_in;
   logic [WS_W-1:0]  rem_ff, rem_in;
   logic [WS_W-1:0]  div_ff, div_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;

   logic [WS_W:0]    rem_shift;
   logic [WS_W:0]    rem_diff;
   logic             fits;

   // One restoring step: shift in the next dividend bit and try to subtract.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[TAG_W-1]};
      fits      = rem_shift >= {1'b0, div_ff};
      rem_diff  = rem_shift - {1'b0, div_ff};
   end

   // Next-state logic of the iteration.
   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      count_in = count_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         quo_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
         count_in = CNT_W'(TAG_W - 1);
         run_in   = 1'b1;
      end else if (run_ff) begin
         quo_in   = {quo_ff[TAG_W-2:0], fits};
         rem_in   = fits ? rem_diff[WS_W-1:0] : rem_shift[WS_W-1:0];
         count_in = count_ff - CNT_W'(1);
         if (count_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      count_ff <= count_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[src/striped_tag_allocator.sv]
// Top level of the striped tag allocator: control, free stack memory and registers.
//
// A get beat that forms a tag goes through a stack read or fresh index, then a
// 31x16 multiply, then the rank add and range check, before its result is
// shown. When the fresh indices are exhausted with an empty stack, the result
// is registered straight from the idle state. A return beat's result waits on
// the bit-serial divider, which produces one quotient bit per cycle. One beat
// is in flight at a time: busy is high from acceptance until the result is
// shown, and stays low for an exhausted get.
// Each result is on rsp_tag_out and rsp_status for exactly one cycle with
// rsp_valid high; the receiver cannot stall it, so it must take it then.
// The free stack needs no clearing after reset; only pushed entries are read.
module striped_tag_allocator #(
   parameter int STACK_DEPTH = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [sta_pkg::TAG_W-1:0]     req_tag_in,
   output logic                          rsp_valid,
   output logic [sta_pkg::TAG_W-1:0]     rsp_tag_out,
   output logic [sta_pkg::STATUS_W-1:0]  rsp_status,
   input  logic                          csr_write,
   input  logic [sta_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sta_pkg::TAG_W-1:0]     csr_data
);
   import sta_pkg::*;

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int TOP_W  = $clog2(STACK_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GET_MUL,
      ST_GET_ADD,
      ST_RET_DIV
   } state_type;

   // Control and configuration registers.
   state_type         state_ff, state_in;
   logic [TOP_W-1:0]  top_ff, top_in;
   logic [TAG_W-1:0]  fresh_ff, fresh_in;
   logic              from_stack_ff, from_stack_in;
   logic [WS_W-1:0]   ws_ff;
   logic [WS_W-1:0]   rank_ff;
   logic [TAG_W-1:0]  limit_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [TAG_W-1:0]    local_ff, local_in;
   logic [PROD_W-1:0]   product_ff, product_in;
   logic [TAG_W-1:0]    rsp_tag_ff, rsp_tag_in;
   status_type          rsp_status_ff, rsp_status_in;

   // Free stack memory.
   logic [TAG_W-1:0]  stack_mem [STACK_DEPTH];
   logic [TAG_W-1:0]  rd_data_ff;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;

   // Divider interface.
   logic              div_start;
   logic              div_done;
   logic [TAG_W-1:0]  div_quo;
   logic [WS_W-1:0]   div_rem;

   logic [WS_W-1:0]   ws_eff;
   logic [TAG_W-1:0]  local_sel;
   logic [PROD_W:0]   full_sum;

   sta_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_tag_in),
      .divisor   (ws_eff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // A world size of zero strides like one.
   assign ws_eff    = (ws_ff == '0) ? WS_W'(1) : ws_ff;
   assign local_sel = from_stack_ff ? rd_data_ff : local_ff;
   assign full_sum  = {1'b0, product_ff} + (PROD_W + 1)'(rank_ff);
   assign rd_addr   = ADDR_W'(top_ff - TOP_W'(1));
   assign wr_addr   = top_ff[ADDR_W-1:0];

   // Sequencer: next state, stack pointers and the result beat.
   always_comb begin
      state_in      = state_ff;
      top_in        = top_ff;
      fresh_in      = fresh_ff;
      from_stack_in = from_stack_ff;
      local_in      = local_ff;
      product_in    = product_ff;
      rsp_valid_in  = 1'b0;
      rsp_tag_in    = '0;
      rsp_status_in = STATUS_OK;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      div_start     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_kind == KIND_GET) begin
                  if (top_ff != '0) begin
                     from_stack_in = 1'b1;
                     rd_en         = 1'b1;
                     state_in      = ST_GET_MUL;
                  end else if (fresh_ff >= limit_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_EXHAUSTED;
                  end else begin
                     from_stack_in = 1'b0;
                     local_in      = fresh_ff;
                     state_in      = ST_GET_MUL;
                  end
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_RET_DIV;
               end
            end
         end
         ST_GET_MUL: begin
            product_in = PROD_W'(local_sel) * PROD_W'(ws_eff);
            state_in   = ST_GET_ADD;
         end
         ST_GET_ADD: begin
            // A tag that does not fit in 31 bits leaves the stack pointer and fresh index untouched.
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (full_sum[PROD_W:TAG_W] != '0) begin
               rsp_status_in = STATUS_EXHAUSTED;
            end else begin
               rsp_tag_in = full_sum[TAG_W-1:0];
               if (from_stack_ff) begin
                  top_in = top_ff - TOP_W'(1);
               end else begin
                  fresh_in = fresh_ff + TAG_W'(1);
               end
            end
         end
         ST_RET_DIV: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (div_rem != rank_ff) begin
                  rsp_status_in = STATUS_WRONG_OWNER;
               end else if (top_ff == TOP_W'(STACK_DEPTH)) begin
                  rsp_status_in = STATUS_STACK_FULL;
               end else begin
                  wr_en  = 1'b1;
                  top_in = top_ff + TOP_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, pointers and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         top_ff        <= '0;
         fresh_ff      <= '0;
         from_stack_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         top_ff        <= top_in;
         fresh_ff      <= fresh_in;
         from_stack_ff <= from_stack_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      local_ff      <= local_in;
      product_ff    <= product_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Configuration registers; writes to an unused index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff    <= WS_W'(1);
         rank_ff  <= '0;
         limit_ff <= INDEX_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WORLD_SIZE:  ws_ff    <= csr_data[WS_W-1:0];
            CSR_RANK:        rank_ff  <= csr_data[WS_W-1:0];
            CSR_INDEX_LIMIT: limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Free stack: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= div_quo;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_tag_out = rsp_tag_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the striped tag allocator: queued requests, tag model and checker.
module tb_top;
   import sta_pkg::*;

   localparam int STACK_DEPTH = 256;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [TAG_W-1:0] TAG_MAX = {TAG_W{1'b1}};

   // One pending beat: either a register write or a tag request.
   typedef struct {
      logic                 is_csr;
      logic [CSR_IDX_W-1:0] csr_idx;
      logic [TAG_W-1:0]     csr_value;
      logic                 kind;
      logic [TAG_W-1:0]     tag;
      logic                 hurry;
   } request_type;

   // One answer as the allocator should give it.
   typedef struct {
      logic [TAG_W-1:0] tag;
      status_type       status;
   } answer_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_kind = KIND_GET;
   logic [TAG_W-1:0]     req_tag_in = '0;
   logic                 rsp_valid;
   logic [TAG_W-1:0]     rsp_tag_out;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_WORLD_SIZE;
   logic [TAG_W-1:0]     csr_data = '0;

   striped_tag_allocator #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_kind    (req_kind),
      .req_tag_in  (req_tag_in),
      .rsp_valid   (rsp_valid),
      .rsp_tag_out (rsp_tag_out),
      .rsp_status  (rsp_status),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // Shadow copy of the allocator state and its registers.
   logic [TAG_W-1:0] free_copy [STACK_DEPTH];
   int unsigned      free_count;
   logic [TAG_W-1:0] fresh_index;
   logic [WS_W-1:0]  world_reg;
   logic [WS_W-1:0]  rank_reg;
   logic [TAG_W-1:0] limit_reg;

   answer_type       expected_answers[$];
   logic [TAG_W-1:0] granted_tags[$];
   request_type      request_queue[$];
   int               errors = 0;
   int unsigned      cycle_count = 0;
   int unsigned      gap_left;

   // Register view that the stimulus side plans with.
   logic [WS_W-1:0]  plan_world = 16'd1;
   logic [WS_W-1:0]  plan_rank = 16'd0;
   logic             plan_hurry = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply a register write to the shadow registers.
   task automatic apply_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [TAG_W-1:0] value);
      case (idx)
         CSR_WORLD_SIZE:  world_reg = value[WS_W-1:0];
         CSR_RANK:        rank_reg = value[WS_W-1:0];
         CSR_INDEX_LIMIT: limit_reg = value;
         default: ;
      endcase
   endtask

   // Work out the answer to one accepted beat and update the shadow state.
   task automatic predict_answer(input logic kind, input logic [TAG_W-1:0] tag);
      logic [WS_W-1:0]  stride;
      logic [TAG_W-1:0] local_index;
      logic [63:0]      formed;
      bit               popped;
      answer_type       ans;
      stride = (world_reg == '0) ? 16'd1 : world_reg;
      ans.tag = '0;
      ans.status = STATUS_OK;
      if (kind == KIND_GET) begin
         popped = (free_count != 0);
         if (popped) begin
            local_index = free_copy[free_count - 1];
         end else begin
            local_index = fresh_index;
         end
         if (!popped && fresh_index >= limit_reg) begin
            ans.status = STATUS_EXHAUSTED;
         end else begin
            formed = 64'(local_index) * 64'(stride) + 64'(rank_reg);
            // A tag that does not fit leaves the state alone.
            if (formed > 64'(TAG_MAX)) begin
               ans.status = STATUS_EXHAUSTED;
            end else begin
               ans.tag = formed[TAG_W-1:0];
               if (popped) begin
                  free_count--;
               end else begin
                  fresh_index++;
               end
               granted_tags.push_back(ans.tag);
               if (granted_tags.size() > 512) void'(granted_tags.pop_front());
            end
         end
      end else if ((tag % stride) != rank_reg) begin
         ans.status = STATUS_WRONG_OWNER;
      end else if (free_count >= STACK_DEPTH) begin
         ans.status = STATUS_STACK_FULL;
      end else begin
         free_copy[free_count] = tag / stride;
         free_count++;
      end
      expected_answers.push_back(ans);
   endtask

   // Driver: presents queued beats, predicts at acceptance, writes registers when idle.
   always @(posedge clock) begin
      logic        nxt_start;
      logic        nxt_write;
      bit          took;
      request_type head;
      if (reset) begin
         start <= 1'b0;
         csr_write <= 1'b0;
         free_count = 0;
         fresh_index = '0;
         world_reg = 16'd1;
         rank_reg = 16'd0;
         limit_reg = INDEX_LIMIT_RESET;
         gap_left = 0;
      end else begin
         nxt_start = start;
         nxt_write = 1'b0;
         took = 1'b0;
         if (start && !busy) begin
            predict_answer(req_kind, req_tag_in);
            head = request_queue.pop_front();
            gap_left = head.hurry ? 0 : $urandom_range(0, 10);
            took = 1'b1;
         end
         if (!start || took) begin
            nxt_start = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (request_queue.size() != 0) begin
               head = request_queue[0];
               if (!head.is_csr) begin
                  nxt_start = 1'b1;
                  req_kind <= head.kind;
                  req_tag_in <= head.tag;
               end else if (expected_answers.size() == 0 && !busy && !rsp_valid
                            && !csr_write) begin
                  // Registers change only once every answer is in.
                  nxt_write = 1'b1;
                  csr_index <= head.csr_idx;
                  csr_data <= head.csr_value;
                  apply_register(head.csr_idx, head.csr_value);
                  void'(request_queue.pop_front());
               end
            end
         end
         start <= nxt_start;
         csr_write <= nxt_write;
      end
   end

   // Monitor: compares each answer beat with the oldest expectation.
   always @(posedge clock) begin
      answer_type exp_ans;
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0) begin
            $display("%0t: unexpected answer, expected none, actual tag %h status %0d",
                     $time, rsp_tag_out, rsp_status);
            errors++;
         end else begin
            exp_ans = expected_answers.pop_front();
            if (rsp_tag_out !== exp_ans.tag) begin
               $display("%0t: tag mismatch, expected %h actual %h",
                        $time, exp_ans.tag, rsp_tag_out);
               errors++;
            end
            if (rsp_status !== exp_ans.status) begin
               $display("%0t: status mismatch, expected %0d actual %0d",
                        $time, exp_ans.status, rsp_status);
               errors++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Queue a register write and track the planned register view.
   task automatic queue_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [TAG_W-1:0] value);
      request_type item;
      item.is_csr = 1'b1;
      item.csr_idx = idx;
      item.csr_value = value;
      item.kind = KIND_GET;
      item.tag = '0;
      item.hurry = 1'b0;
      request_queue.push_back(item);
      if (idx == CSR_WORLD_SIZE) plan_world = value[WS_W-1:0];
      if (idx == CSR_RANK) plan_rank = value[WS_W-1:0];
   endtask

   // Queue a request, keeping the queue short so returns can follow the grants.
   task automatic queue_request(input logic kind, input logic [TAG_W-1:0] tag);
      request_type item;
      item.is_csr = 1'b0;
      item.csr_idx = CSR_WORLD_SIZE;
      item.csr_value = '0;
      item.kind = kind;
      item.tag = tag;
      item.hurry = plan_hurry;
      request_queue.push_back(item);
      while (request_queue.size() > 4) @(posedge clock);
   endtask

   // Choose a tag to give back: mostly a granted or well-formed one, sometimes noise.
   function automatic logic [TAG_W-1:0] pick_return_tag();
      int unsigned roll;
      int unsigned pick;
      logic [63:0] stride;
      logic [63:0] span;
      logic [63:0] local_index;
      logic [63:0] formed;
      stride = (plan_world == '0) ? 64'd1 : 64'(plan_world);
      if (64'(plan_rank) < stride) begin
         span = (64'(TAG_MAX) - 64'(plan_rank)) / stride;
         if ($urandom_range(0, 3) == 0) begin
            local_index = 64'($urandom_range(0, 32'(span)));
         end else begin
            local_index = 64'($urandom_range(0, 300));
            if (local_index > span) local_index = span;
         end
         formed = local_index * stride + 64'(plan_rank);
      end else begin
         formed = 64'(31'($urandom()));
      end
      roll = $urandom_range(0, 99);
      if (roll < 45 && granted_tags.size() != 0) begin
         pick = $urandom_range(0, granted_tags.size() - 1);
         pick_return_tag = granted_tags[pick];
         // Now and then the tag stays in the pool and comes back twice.
         if ($urandom_range(0, 9) != 0) granted_tags.delete(pick);
      end else if (roll < 80) begin
         pick_return_tag = formed[TAG_W-1:0];
      end else if (roll < 92) begin
         pick_return_tag = 31'($urandom());
      end else begin
         pick_return_tag = 31'(formed + 64'd1);
      end
   endfunction

   // One random phase under one register setting.
   task automatic run_phase(input logic [WS_W-1:0] ws, input logic [WS_W-1:0] rk,
                            input logic [TAG_W-1:0] limit, input int ret_pct,
                            input int count, input logic hurry);
      queue_register(CSR_WORLD_SIZE, 31'(ws));
      queue_register(CSR_RANK, 31'(rk));
      queue_register(CSR_INDEX_LIMIT, limit);
      plan_hurry = hurry;
      repeat (count) begin
         if ($urandom_range(0, 99) < ret_pct) begin
            queue_request(KIND_RETURN, pick_return_tag());
         end else begin
            queue_request(KIND_GET, 31'($urandom()));
         end
      end
   endtask

   // Stimulus: directed cases, random phases, then drain and report.
   initial begin
      logic [WS_W-1:0] ws;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Fresh grants, returns at both ends of the tag range, and a double return.
      queue_request(KIND_GET, TAG_MAX);
      queue_request(KIND_GET, 31'($urandom()));
      queue_request(KIND_RETURN, TAG_MAX);
      queue_request(KIND_RETURN, 31'd0);
      queue_request(KIND_RETURN, 31'd0);
      queue_request(KIND_GET, 31'd0);
      queue_request(KIND_GET, 31'd0);
      queue_request(KIND_GET, 31'($urandom()));
      queue_request(KIND_GET, 31'd0);

      // Widest stride and top rank with the smallest bound: stack pops and wrong owner.
      queue_register(CSR_WORLD_SIZE, 31'd65535);
      queue_register(CSR_RANK, 31'd65534);
      queue_register(CSR_INDEX_LIMIT, 31'd1);
      queue_request(KIND_GET, 31'd0);
      queue_request(KIND_RETURN, 31'd65534);
      queue_request(KIND_RETURN, 31'd2147450879);
      queue_request(KIND_GET, 31'd0);
      queue_request(KIND_GET, 31'd0);
      queue_request(KIND_RETURN, 31'd5);
      queue_request(KIND_RETURN, TAG_MAX);

      // Push a large index, then pop it under a stride where the tag does not fit.
      queue_register(CSR_WORLD_SIZE, 31'd1);
      queue_register(CSR_RANK, 31'd0);
      queue_register(CSR_INDEX_LIMIT, INDEX_LIMIT_RESET);
      queue_request(KIND_RETURN, 31'd32768);
      queue_register(CSR_WORLD_SIZE, 31'd65535);
      queue_register(CSR_RANK, 31'd65534);
      queue_request(KIND_GET, 31'd0);

      // A zero world size acts as a stride of one.
      queue_register(CSR_WORLD_SIZE, 31'd0);
      queue_register(CSR_RANK, 31'd0);
      queue_request(KIND_GET, 31'd0);
      queue_request(KIND_GET, 31'd0);

      // Rank at or above the world size: returns are never owned, gets still form.
      queue_register(CSR_WORLD_SIZE, 31'd3);
      queue_register(CSR_RANK, 31'd5);
      queue_request(KIND_RETURN, 31'd5);
      queue_request(KIND_GET, 31'd0);

      // Random phases; the first one fills the stack past its depth.
      run_phase(16'd1, 16'd0, INDEX_LIMIT_RESET, 97, 300, 1'b0);
      run_phase(16'd0, 16'd0, INDEX_LIMIT_RESET, 20, 120, 1'b1);
      run_phase(16'd65535, 16'd65534, INDEX_LIMIT_RESET, 50, 100, 1'b0);
      ws = 16'($urandom_range(2, 16));
      run_phase(ws, 16'($urandom_range(0, ws - 1)), 31'($urandom_range(1, 40)), 45, 100,
                1'b1);
      ws = 16'($urandom_range(2, 200));
      run_phase(ws, 16'(ws + $urandom_range(0, 100)), INDEX_LIMIT_RESET, 40, 60, 1'b0);
      ws = 16'($urandom_range(1, 65535));
      run_phase(ws, 16'($urandom_range(0, ws - 1)), 31'($urandom_range(1, 2100000000)),
                50, 120, 1'b0);

      // Drain everything, then allow for a late stray beat.
      while (request_queue.size() != 0 || expected_answers.size() != 0 || start)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0 && expected_answers.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
src/sta_pkg.sv
src/sta_divider.sv
src/striped_tag_allocator.sv
tb/tb_top.sv
